// File: design/sha256_message_hash_defines.svh
// Assertion macros for the SHA-256 message hasher.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SHA256_MESSAGE_HASH_DEFINES_SVH
`define SHA256_MESSAGE_HASH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define SHAMH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("shamh check failed");
// Next-cycle implication, disabled while reset is asserted
`define SHAMH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("shamh check failed");
`else
`define SHAMH_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SHAMH_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: design/shamh_pkg.sv
// Shared types and constants for the SHA-256 message hasher.
// No dependencies; imported by the schedule, round and top modules.
package shamh_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [7:0][31:0] word8_t;

    // Control from the sequencer to the datapath units
    typedef struct packed {
        logic byte_shift;  // shift one byte into the block window
        logic work_load;   // load working variables from the hash state
        logic round_step;  // run one compression round
    } unit_ctrl_t;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash values; element 0 is H0
    localparam word8_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

// File: design/shamh_sched.sv
// Block window and rolling message schedule for the SHA-256 hasher.
// Depends on shamh_pkg; bytes shift in, then the window rolls one word per round.
module shamh_sched import shamh_pkg::*; (
    input  logic       aclk,
    input  unit_ctrl_t ctrl,
    input  logic [7:0] byte_in,
    output word_t      w_out
);

    word_t win_reg [16];
    word_t w_new;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Next schedule word from the current window W[t..t+15]
    assign w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign w_out = win_reg[0];

    // Shift bytes in big-endian, or roll the window by one word
    always_ff @(posedge aclk) begin
        if (ctrl.byte_shift) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], byte_in};
        end else if (ctrl.round_step) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

endmodule

// File: design/shamh_round.sv
// Shared compression round unit for the SHA-256 hasher.
// Depends on shamh_pkg; holds the working variables a..h.
module shamh_round import shamh_pkg::*; (
    input  logic       aclk,
    input  unit_ctrl_t ctrl,
    input  word8_t     hash_in,
    input  word_t      k_in,
    input  word_t      w_in,
    output word8_t     work_out
);

    word8_t work_reg;
    word_t  t1;
    word_t  t2;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // Round sums: a is element 0, h is element 7
    assign t1 = work_reg[7] + bsig1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + k_in + w_in;
    assign t2 = bsig0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    assign work_out = work_reg;

    // Load from hash state or advance one round
    always_ff @(posedge aclk) begin
        if (ctrl.work_load) begin
            work_reg <= hash_in;
        end else if (ctrl.round_step) begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

endmodule

// File: design/sha256_message_hash.sv
// Top level of the SHA-256 message hasher: sequencer, hash state, digest buffer.
// Depends on shamh_pkg, shamh_sched, shamh_round and the assertion macro header.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  request | s_valid s_ready s_data_byte s_byte_valid s_last | in
//  digest  | m_valid m_ready m_digest_word m_word_index     | out
//          | m_last_word                                    |
//
// Message bytes are accepted in S_IDLE; the 64th byte of a block starts the compression
// rounds (S_ROUND), followed by the hash update (S_UPDATE).
// A last request pads one byte per cycle to the block end, then compresses it; a second
// final block is padded and compressed when the length does not fit. S_DONE loads the buffer.
// Reset (aresetn low, synchronous) restores the initial hash and an empty message.
// s_ready is high only in S_IDLE; a stalled digest holds the next digest load and new input.
`include "sha256_message_hash_defines.svh"
module sha256_message_hash import shamh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ROUND  = 5'b00010,
        S_UPDATE = 5'b00100,
        S_PAD    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    word8_t      hash_reg, hash_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        pad_pend_reg, pad_pend_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_ok_reg, len_ok_next;
    logic        final_reg, final_next;
    word8_t      obuf_reg;
    logic        ovalid_reg;
    logic [2:0]  oidx_reg;
    logic        obuf_load;

    unit_ctrl_t  ctrl;
    logic [7:0]  shift_byte;
    logic [7:0]  pad_byte;
    logic [63:0] len_bits;
    logic        s_acc;
    logic        m_acc;
    word_t       w_cur;
    word8_t      work;

    assign s_ready = (state_reg == S_IDLE);
    assign s_acc   = s_valid & s_ready;
    assign m_acc   = ovalid_reg & m_ready;

    // Padding byte: marker, then zeros, then the big-endian bit length
    assign len_bits = {count_reg, 3'b000};
    always_comb begin
        if (pad_first_reg) begin
            pad_byte = PAD_MARK;
        end else if (len_ok_reg && (fill_reg >= LEN_POS)) begin
            pad_byte = len_bits[{3'(3'd7 - fill_reg[2:0]), 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign shift_byte = (state_reg == S_PAD) ? pad_byte : s_data_byte;

    shamh_sched u_sched (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .byte_in (shift_byte),
        .w_out   (w_cur)
    );

    shamh_round u_round (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .hash_in  (hash_reg),
        .k_in     (ROUND_K[rnd_reg]),
        .w_in     (w_cur),
        .work_out (work)
    );

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        rnd_next       = rnd_reg;
        pad_pend_next  = pad_pend_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        ctrl           = '0;
        obuf_load      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_byte_valid) begin
                        ctrl.byte_shift = 1'b1;
                        fill_next       = fill_reg + 6'd1;
                        count_next      = count_reg + 61'd1;
                    end
                    if (s_last) begin
                        pad_pend_next  = 1'b1;
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                    end
                    if (s_byte_valid && (fill_reg == 6'd63)) begin
                        ctrl.work_load = 1'b1;
                        state_next     = S_ROUND;
                    end else if (s_last) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                ctrl.round_step = 1'b1;
                rnd_next        = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + work[i];
                end
                if (pad_pend_reg) begin
                    state_next = S_PAD;
                end else if (final_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PAD: begin
                ctrl.byte_shift = 1'b1;
                fill_next       = fill_reg + 6'd1;
                pad_first_next  = 1'b0;
                if ((pad_first_reg && (fill_reg < LEN_POS)) || (fill_reg == 6'd63)) begin
                    len_ok_next = 1'b1;
                end
                if (fill_reg == 6'd63) begin
                    ctrl.work_load = 1'b1;
                    state_next     = S_ROUND;
                    if (len_ok_reg) begin
                        pad_pend_next = 1'b0;
                        final_next    = 1'b1;
                    end
                end
            end
            S_DONE: begin
                // Hand the digest to the output buffer once it has drained
                if (!ovalid_reg) begin
                    obuf_load   = 1'b1;
                    hash_next   = HASH_IV;
                    count_next  = '0;
                    final_next  = 1'b0;
                    len_ok_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            hash_reg      <= HASH_IV;
            count_reg     <= '0;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            pad_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            rnd_reg       <= rnd_next;
            pad_pend_reg  <= pad_pend_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
        end
    end

    // Digest buffer: load eight words, drain one per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
        end else if (obuf_load) begin
            ovalid_reg <= 1'b1;
            oidx_reg   <= '0;
        end else if (m_acc) begin
            oidx_reg <= oidx_reg + 3'd1;
            if (oidx_reg == 3'd7) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (obuf_load) begin
            obuf_reg <= hash_reg;
        end else if (m_acc) begin
            for (int i = 0; i < 7; i++) begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
        end
    end

    assign m_valid       = ovalid_reg;
    assign m_digest_word = obuf_reg[0];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 3'd7);

    // Round counter runs only inside a compression
    `SHAMH_ASSERT_IMPL(a_rnd_idle, aclk, aresetn, rnd_reg != 6'd0, state_reg == S_ROUND)
    // The eighth word empties the buffer
    `SHAMH_ASSERT_NEXT(a_drain, aclk, aresetn, m_acc && m_last_word, !m_valid)
    // A digest load starts at word zero and restores the initial hash
    `SHAMH_ASSERT_NEXT(a_load, aclk, aresetn, obuf_load,
        m_valid && (m_word_index == 3'd0) && (hash_reg == HASH_IV) && (count_reg == 61'd0))
    // The buffer is never overwritten while words remain
    `SHAMH_ASSERT_IMPL(a_no_clobber, aclk, aresetn, obuf_load, !ovalid_reg)

endmodule
